// ===== design/positional_list_engine_defines.svh =====
// assertion macros for the positional list engine checker
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// antecedent implies consequent in the next cycle
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ===== design/ple_pkg.sv =====
// shared types and constants of the positional list engine
`default_nettype none

package ple_pkg;

   localparam int VALUE_W    = 32;
   localparam int POS_W      = 4;
   localparam int OP_W       = 2;
   localparam int CELL_IDX_W = 7;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic               ins;
      logic               del;
      logic [POS_W-1:0]   slot;
      logic [VALUE_W-1:0] key;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== design/ple_cell.sv =====
// one list cell: holds an entry, shifts with its neighbours, compares against the key
`default_nettype none

module ple_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                          clock,
   input  wire ple_pkg::cell_ctl_type         ctl,
   input  wire logic [ple_pkg::VALUE_W-1:0]   left_value,
   input  wire logic [ple_pkg::VALUE_W-1:0]   right_value,
   output logic      [ple_pkg::VALUE_W-1:0]   entry_value,
   output logic                               match
);

   localparam logic [ple_pkg::CELL_IDX_W-1:0] IDX = ple_pkg::CELL_IDX_W'(INDEX);

   logic [ple_pkg::VALUE_W-1:0]    entry_ff;
   logic [ple_pkg::VALUE_W-1:0]    entry_in;
   logic [ple_pkg::CELL_IDX_W-1:0] slot_ext;

   assign slot_ext = ple_pkg::CELL_IDX_W'(ctl.slot);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins) begin
         if (IDX == slot_ext) begin
            entry_in = ctl.key;
         end else if (IDX > slot_ext) begin
            entry_in = left_value;
         end
      end else if (ctl.del) begin
         // close the gap from the right
         if (IDX >= slot_ext) begin
            entry_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;
   assign match       = (entry_ff == ctl.key);

endmodule

`default_nettype wire

// ===== design/ple_first_match.sv =====
// priority encoder: one-based position of the lowest set match bit
`default_nettype none

module ple_first_match #(
   parameter int N  = 8,
   parameter int PW = $clog2(N + 1)
) (
   input  wire logic [N-1:0]  match,
   output logic               hit,
   output logic [PW-1:0]      position
);

   always_comb begin
      position = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (match[i]) begin
            position = PW'(i + 1);
         end
      end
   end

   assign hit = |match;

endmodule

`default_nettype wire

// ===== design/positional_list_engine.sv =====
// top level of the positional list engine: cell chain, control and result register
//
// usage
//   request channel req_*: req_op (0 insert, 1 delete, 2 search), req_position
//   (one-based) and req_value. a transfer happens on a rising edge with
//   req_valid high and req_stall low.
//   result channel rsp_*: rsp_ok, rsp_found_position, rsp_read_value and
//   rsp_entry_count, one result per request, in request order.
// timing
//   on the transfer edge the cell chain shifts and every cell's compare of
//   its entry with the key is registered in the match stage. the priority
//   encoder works on the match stage, and the result register takes its
//   output when the match stage advances. a new request is taken only once
//   the match stage has passed the last request on to the result register.
// stalling
//   while rsp_stall holds a result, the result register keeps its payload
//   and the encoded result waits in the match stage; req_stall stays high
//   until that stage has drained.
// reset
//   reset empties the list (count zero) and drops any pending result; the
//   entry storage itself is not cleared since only entries below the count
//   are ever read.
`default_nettype none

module positional_list_engine #(
   parameter int CAPACITY = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic        [ple_pkg::OP_W-1:0]     req_op,
   input  wire logic        [ple_pkg::POS_W-1:0]    req_position,
   input  wire logic signed [ple_pkg::VALUE_W-1:0]  req_value,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_ok,
   output logic             [ple_pkg::POS_W-1:0]    rsp_found_position,
   output logic signed      [ple_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic             [ple_pkg::POS_W-1:0]    rsp_entry_count
);

   // count width, and a compare width wide enough for count + 1 and position
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;
   localparam int PW   = $clog2(CAPACITY + 1);

   // list count
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;

   // match stage
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_ok_ff;
   logic                          s1_search_ff;
   logic [CAPACITY-1:0]           s1_match_ff;
   logic [ple_pkg::VALUE_W-1:0]   s1_read_ff;
   logic [CW-1:0]                 s1_count_ff;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_ok_ff;
   logic [ple_pkg::POS_W-1:0]     rsp_found_ff;
   logic [ple_pkg::VALUE_W-1:0]   rsp_read_ff;
   logic [ple_pkg::POS_W-1:0]     rsp_count_ff;

   logic                          req_xfer;
   logic                          s1_adv;
   logic                          ins_ok;
   logic                          del_ok;
   logic [CMPW-1:0]               pos_ext;
   logic [CMPW-1:0]               cnt_ext;
   logic [ple_pkg::POS_W-1:0]     slot;
   logic [ple_pkg::VALUE_W-1:0]   read_sel;
   logic [CAPACITY-1:0]           cell_match;
   logic [CAPACITY-1:0]           live_match;
   logic [ple_pkg::VALUE_W-1:0]   cell_value [CAPACITY];
   ple_pkg::cell_ctl_type         ctl;
   logic                          enc_hit;
   logic [PW-1:0]                 enc_pos;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = s1_valid_ff;
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);

   assign pos_ext = CMPW'(req_position);
   assign cnt_ext = CMPW'(cnt_ff);
   assign slot    = req_position - ple_pkg::POS_W'(1);

   // request decode
   always_comb begin
      ins_ok = 1'b0;
      del_ok = 1'b0;
      unique case (req_op)
         ple_pkg::OP_INSERT: begin
            ins_ok = (cnt_ext < CMPW'(CAPACITY)) && (req_position != '0) &&
                     (pos_ext <= cnt_ext + CMPW'(1));
         end
         ple_pkg::OP_DELETE: begin
            del_ok = (cnt_ff != '0) && (req_position != '0) && (pos_ext <= cnt_ext);
         end
         default: begin
         end
      endcase
   end

   // broadcast to the chain, only on a transfer
   always_comb begin
      ctl.ins  = req_xfer && ins_ok;
      ctl.del  = req_xfer && del_ok;
      ctl.slot = slot;
      ctl.key  = req_value;
   end

   // the chain of cells
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ple_pkg::VALUE_W-1:0] left_v;
      logic [ple_pkg::VALUE_W-1:0] right_v;

      if (g == 0) begin : g_first
         assign left_v = cell_value[g];
      end else begin : g_left
         assign left_v = cell_value[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_v = cell_value[g];
      end else begin : g_right
         assign right_v = cell_value[g+1];
      end

      ple_cell #(
         .INDEX(g)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .left_value  (left_v),
         .right_value (right_v),
         .entry_value (cell_value[g]),
         .match       (cell_match[g])
      );

      // only entries in use may match
      assign live_match[g] = cell_match[g] && (CMPW'(g) < cnt_ext);
   end

   // value leaving on a delete
   always_comb begin
      read_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (CMPW'(i) == CMPW'(slot)) begin
            read_sel = cell_value[i];
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.ins) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (ctl.del) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end
   end

   ple_first_match #(
      .N  (CAPACITY),
      .PW (PW)
   ) u_first_match (
      .match    (s1_match_ff),
      .hit      (enc_hit),
      .position (enc_pos)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ok_ff     <= ins_ok || del_ok;
         s1_search_ff <= (req_op == ple_pkg::OP_SEARCH);
         s1_match_ff  <= live_match;
         s1_read_ff   <= del_ok ? read_sel : '0;
         s1_count_ff  <= cnt_in;
      end
      if (s1_adv) begin
         rsp_ok_ff    <= s1_ok_ff || (s1_search_ff && enc_hit);
         rsp_found_ff <= (s1_search_ff && enc_hit) ? ple_pkg::POS_W'(enc_pos) : '0;
         rsp_read_ff  <= s1_read_ff;
         rsp_count_ff <= ple_pkg::POS_W'(s1_count_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_read_value     = rsp_read_ff;
   assign rsp_entry_count    = rsp_count_ff;

endmodule

`default_nettype wire

// ===== design/ple_checker.sv =====
// port-level assertions for the positional list engine, bound to the top level
`default_nettype none
`include "positional_list_engine_defines.svh"

module ple_checker #(
   parameter int CAPACITY = 8
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic                                rsp_ok,
   input wire logic        [ple_pkg::POS_W-1:0]    rsp_found_position,
   input wire logic signed [ple_pkg::VALUE_W-1:0]  rsp_read_value,
   input wire logic        [ple_pkg::POS_W-1:0]    rsp_entry_count
);

   // a held result keeps its payload
   `PLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_ok) && $stable(rsp_found_position) && $stable(rsp_read_value) && $stable(rsp_entry_count))

   // one request in flight: after a transfer the request side is stalled in the next cycle
   `PLE_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // a search hit is an ok result and removes nothing
   `PLE_ASSERT_NOW(a_hit_consistent, clock, reset, rsp_valid && (rsp_found_position != '0), rsp_ok && (rsp_read_value == '0))

   // a failed request reports no removed value
   `PLE_ASSERT_NOW(a_fail_no_value, clock, reset, rsp_valid && !rsp_ok, (rsp_read_value == '0) && (rsp_found_position == '0))

   // the reported count never passes the capacity (checked for capacities up to 15)
   `PLE_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, (CAPACITY > 15) || (32'(rsp_entry_count) <= CAPACITY))

endmodule

bind positional_list_engine ple_checker #(
   .CAPACITY(CAPACITY)
) u_ple_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_ok             (rsp_ok),
   .rsp_found_position (rsp_found_position),
   .rsp_read_value     (rsp_read_value),
   .rsp_entry_count    (rsp_entry_count)
);

`default_nettype wire
